// ----- hw/rtl/crx_pkg.sv -----
// ----------------------------------------------------------------------------
// crx_pkg
// Shared types and constants for the column range extractor.
// ----------------------------------------------------------------------------
package crx_pkg;

	localparam int LINE_MAX   = 1024;
	localparam int NUM_RANGES = 7;

	localparam int COL_W     = 10;
	localparam int EMIT_W    = $clog2(LINE_MAX);
	localparam int RANGE_W   = 21;
	localparam int CFG_IDX_W = 3;
	localparam int COUNT_W   = 3;

	localparam logic [COL_W-1:0]  COL_TOP  = {COL_W{1'b1}};
	localparam logic [EMIT_W-1:0] EMIT_MAX = EMIT_W'(LINE_MAX - 1);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_FIRST = 3'd1;

	// range register fields
	localparam int RNG_START_LSB = 0;
	localparam int RNG_STOP_LSB  = 10;
	localparam int RNG_OPEN_BIT  = 20;

	typedef struct packed {
		logic [7:0] in_char;
		logic       line_done;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       end_of_line;
		logic       last_of_run;
	} out_item_t;

	// classified item handed from front to back
	typedef struct packed {
		logic [7:0]            ch;
		logic                  line_done;
		logic [NUM_RANGES-1:0] hits;
	} job_t;

endpackage

// ----- hw/rtl/column_range_extractor.sv -----
// ----------------------------------------------------------------------------
// column_range_extractor
// Passes on the characters of a text line whose columns lie in configured
// ranges, once per matching range within a per-line limit; marks each line end.
// ----------------------------------------------------------------------------
// usage:
//   input channel: drive item and raise push; a transfer happens on a clock
//   edge with push high and full low. item.line_done closes the line.
//   result channel: while empty is low the oldest result sits on result;
//   raise pop to take it. last_of_run flags the final result of a character.
//   config channel: cfg_ready is always high; index 0 is range_count,
//   indexes 1 to 7 are range_0 to range_6. write only while the block idles.
// timing:
//   a character is classified at its transfer; its results pass through the
//   job queue and the output queue before they reach the result port. the
//   back-end sequencer gives one result per cycle for each range a character
//   hits while the output queue has room; a character with no hit leaves the
//   job queue without a result, so the sustained rate is one character per
//   cycle while each hits at most one range and the receiver keeps up.
// reset clears the column, per-line count, both queues and control registers.
// a stalled receiver fills the output queue, then the job queue, then full
// rises; nothing is dropped.
// ----------------------------------------------------------------------------
module column_range_extractor
	import crx_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// input queue side
	input  logic                 push,
	input  in_item_t             item,
	output logic                 full,
	// result queue side
	input  logic                 pop,
	output out_item_t            result,
	output logic                 empty,
	// configuration writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [RANGE_W-1:0]   cfg_data
);

	job_t job;
	job_t head;
	logic job_push;
	logic job_full;
	logic head_valid;
	logic head_pop;

	// config writes are always taken
	assign cfg_ready = 1'b1;
	assign full      = job_full;

	// front: column tracking and range classification
	crx_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.item      (item),
		.job_full  (job_full),
		.job_push  (job_push),
		.job       (job)
	);

	// decouples classification from result sequencing
	crx_job_queue u_job_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (job_push),
		.wr_job     (job),
		.full       (job_full),
		.rd_en      (head_pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// back: one result per cycle unless stalled, line limit, output queue
	crx_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.head_pop   (head_pop),
		.pop        (pop),
		.empty      (empty),
		.result     (result)
	);

endmodule

// ----- hw/rtl/crx_front.sv -----
// ----------------------------------------------------------------------------
// crx_front
// Holds the range registers and the column counter; tags each character
// with the set of ranges it falls in.
// ----------------------------------------------------------------------------
module crx_front
	import crx_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [RANGE_W-1:0]   cfg_data,
	input  logic                 push,
	input  in_item_t             item,
	input  logic                 job_full,
	output logic                 job_push,
	output job_t                 job
);

	logic [COUNT_W-1:0] range_count_q;
	logic [RANGE_W-1:0] range_q [NUM_RANGES];
	logic [COL_W-1:0]   col_q;
	logic               past_q;
	logic [COUNT_W-1:0] used;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_count_q <= '0;
			for (int i = 0; i < NUM_RANGES; i++) begin
				range_q[i] <= '0;
			end
		end else if (cfg_valid) begin
			if (cfg_index == REG_RANGE_COUNT) begin
				range_count_q <= cfg_data[COUNT_W-1:0];
			end
			for (int i = 0; i < NUM_RANGES; i++) begin
				if (cfg_index == REG_RANGE_FIRST + CFG_IDX_W'(i)) begin
					range_q[i] <= cfg_data;
				end
			end
		end
	end

	assign used = (range_count_q > COUNT_W'(NUM_RANGES)) ? COUNT_W'(NUM_RANGES)
	                                                      : range_count_q;

	always_comb begin
		job.ch        = item.in_char;
		job.line_done = item.line_done;
		for (int i = 0; i < NUM_RANGES; i++) begin
			logic [COL_W-1:0] start;
			logic [COL_W-1:0] stop;
			logic             open;
			start = range_q[i][RNG_START_LSB +: COL_W];
			stop  = range_q[i][RNG_STOP_LSB +: COL_W];
			open  = range_q[i][RNG_OPEN_BIT];
			if (COUNT_W'(i) >= used || item.line_done) begin
				job.hits[i] = 1'b0;
			end else if (past_q) begin
				job.hits[i] = open;
			end else begin
				job.hits[i] = (col_q >= start) && (open || col_q <= stop);
			end
		end
	end

	assign job_push = push && !job_full;

	// column tracking, saturating as "beyond last column"
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			past_q <= 1'b0;
		end else if (job_push) begin
			if (item.line_done) begin
				col_q  <= '0;
				past_q <= 1'b0;
			end else if (!past_q) begin
				if (col_q == COL_TOP) begin
					past_q <= 1'b1;
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
		end
	end

endmodule

// ----- hw/rtl/crx_job_queue.sv -----
// ----------------------------------------------------------------------------
// crx_job_queue
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
module crx_job_queue
	import crx_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  job_t wr_job,
	output logic full,
	input  logic rd_en,
	output logic head_valid,
	output job_t head
);

	job_t       mem [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(wr_en) - 2'(rd_en);
		end
	end

	assign full       = count_q == 2'd2;
	assign head_valid = count_q != 2'd0;
	assign head       = mem[rd_ptr_q];

endmodule

// ----- hw/rtl/crx_back.sv -----
// ----------------------------------------------------------------------------
// crx_back
// Walks the head item's hit set, one result per cycle while the two-entry
// output queue has room, applies the per-line output limit, buffers results.
// ----------------------------------------------------------------------------
module crx_back
	import crx_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  job_t      head,
	output logic      head_pop,
	input  logic      pop,
	output logic      empty,
	output out_item_t result
);

	logic [NUM_RANGES-1:0] served_q;
	logic [EMIT_W-1:0]     emitted_q;
	logic [NUM_RANGES-1:0] pending;
	logic [NUM_RANGES-1:0] low_bit;
	logic [NUM_RANGES-1:0] rest;
	logic                  out_full;
	logic                  out_push;
	logic                  out_pop;
	logic                  last;
	out_item_t             out_new;

	out_item_t  omem [2];
	logic       owr_q;
	logic       ord_q;
	logic [1:0] ocount_q;

	assign pending = head.hits & ~served_q;
	assign low_bit = pending & (~pending + NUM_RANGES'(1));
	assign rest    = pending & ~low_bit;
	assign last    = (rest == '0) || (emitted_q + EMIT_W'(1) == EMIT_MAX);

	always_comb begin
		out_push = 1'b0;
		head_pop = 1'b0;
		out_new  = '{out_char: head.ch, end_of_line: 1'b0, last_of_run: last};
		if (head_valid) begin
			if (head.line_done) begin
				out_new  = '{out_char: 8'd0, end_of_line: 1'b1, last_of_run: 1'b1};
				out_push = !out_full;
				head_pop = !out_full;
			end else if (pending == '0 || emitted_q == EMIT_MAX) begin
				// nothing selected or line already at its limit
				head_pop = 1'b1;
			end else begin
				out_push = !out_full;
				head_pop = !out_full && last;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			served_q  <= '0;
			emitted_q <= '0;
		end else begin
			if (head_pop) begin
				served_q <= '0;
			end else if (out_push) begin
				served_q <= served_q | low_bit;
			end
			if (head_pop && head.line_done) begin
				emitted_q <= '0;
			end else if (out_push) begin
				emitted_q <= emitted_q + EMIT_W'(1);
			end
		end
	end

	// output queue
	assign out_full = ocount_q == 2'd2;
	assign empty    = ocount_q == 2'd0;
	assign out_pop  = pop && !empty;
	assign result   = omem[ord_q];

	always_ff @(posedge clk) begin
		if (out_push) begin
			omem[owr_q] <= out_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q    <= 1'b0;
			ord_q    <= 1'b0;
			ocount_q <= '0;
		end else begin
			if (out_push) begin
				owr_q <= !owr_q;
			end
			if (out_pop) begin
				ord_q <= !ord_q;
			end
			ocount_q <= ocount_q + 2'(out_push) - 2'(out_pop);
		end
	end

endmodule
